FILE: rtl/acrms_pkg.sv
// acrms_pkg: shared constants and types for the ac rms envelope detector
// no dependencies; used by ac_rms_envelope_detector_unit
`timescale 1ns / 1ps

package acrms_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int STAGES      = 4;
  localparam int STG_W       = $clog2(STAGES);

  // baseline and power state widths
  localparam int BASE_W = SAMPLE_BITS + FRAC_BITS;
  localparam int POW_W  = 2 * SAMPLE_BITS + FRAC_BITS;

  // average datapath
  localparam int DIFF_W = POW_W + 1;
  localparam int PROD_W = DIFF_W + WEIGHT_BITS + 1;
  localparam int SQ_W   = 2 * BASE_W;

  // square root: radicand has 2*ROOT_FRAC fraction bits
  localparam int ROOT_FRAC = 8;
  localparam int RAD_W     = 2 * SAMPLE_BITS + 2 * ROOT_FRAC;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int CNT_W     = $clog2(ROOT_W);

  // ports
  localparam int SAMPLE_W    = 12;
  localparam int OUT_W       = 20;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BASELINE_WEIGHT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_POWER_WEIGHT    = 1'b1;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd656;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_SQR,
    ST_PIN,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/ac_rms_envelope_detector_unit.sv
// ac_rms_envelope_detector_unit: baseline removal, power smoothing and rms root
// depends on acrms_pkg
`timescale 1ns / 1ps

// channel   direction  content
// in_       slave      tdata[11:0] sample
// out_      master     tdata[19:0] rms_level
// cfg_      write      addr 0 baseline_weight, addr 1 power_weight
//
// one transaction at a time: each sample takes eight read-multiply-update passes over the
// stage memories (a read-multiply state and an update state each), with the squaring of the
// ac part (square and load states) after the fourth pass, then the bit-serial square root
// and a load of the output register.
// reset clears stage valid bits at once, so stages read as zero until written.
// a finished result waits in the output register while the next sample runs;
// the next result waits in its last state until the output register is free.

module ac_rms_envelope_detector_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [acrms_pkg::IN_TDATA_W-1:0]       in_tdata,   // [11:0] sample
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [acrms_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [19:0] rms_level
  input  logic                                   cfg_we,
  input  logic [acrms_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [acrms_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int BASE_W = acrms_pkg::BASE_W;
  localparam int POW_W  = acrms_pkg::POW_W;
  localparam int STG_W  = acrms_pkg::STG_W;
  localparam int WB     = acrms_pkg::WEIGHT_BITS;
  localparam int FB     = acrms_pkg::FRAC_BITS;
  localparam int ROOT_W = acrms_pkg::ROOT_W;
  localparam int RAD_W  = acrms_pkg::RAD_W;
  localparam int CNT_W  = acrms_pkg::CNT_W;

  // stage memories
  logic [BASE_W-1:0] base_mem [acrms_pkg::STAGES];
  logic [POW_W-1:0]  pow_mem  [acrms_pkg::STAGES];
  logic [acrms_pkg::STAGES-1:0] base_vld_r, pow_vld_r;
  logic [BASE_W-1:0] base_rd_r;
  logic [POW_W-1:0]  pow_rd_r;
  logic              base_rdv_r, pow_rdv_r;

  logic              rd_en;
  logic [STG_W:0]    rd_stg;
  logic              wr_en;

  acrms_pkg::state_t state_r, state_nxt;
  logic [STG_W:0]    stg_r, stg_nxt;
  logic [WB-1:0]     bw_r, pw_r;
  logic [BASE_W-1:0] xs_r, xs_nxt;
  logic [POW_W-1:0]  x_r, x_nxt;
  logic [POW_W-1:0]  y_r, y_nxt;
  logic signed [acrms_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [BASE_W-1:0] mag_r, mag_nxt;
  logic [acrms_pkg::SQ_W-1:0] sq_r, sq_nxt;
  logic [RAD_W-1:0]  v_r, v_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [acrms_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  // combinational helpers
  logic [POW_W-1:0]  y_cur;
  logic [WB-1:0]     w_cur;
  logic signed [acrms_pkg::DIFF_W-1:0] diff;
  logic signed [acrms_pkg::PROD_W-1:0] prod_rnd;
  logic signed [acrms_pkg::PROD_W-1:0] step;
  logic [POW_W-1:0]  ynew;
  logic [BASE_W-1:0] yb;
  logic [acrms_pkg::SQ_W:0] sq_rnd;
  logic [POW_W+2*acrms_pkg::ROOT_FRAC-1:0] rad_wide;
  logic [ROOT_W+1:0] rem_sh, trial;

  assign in_tready  = (state_r == acrms_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(acrms_pkg::OUT_TDATA_W - acrms_pkg::OUT_W){1'b0}}, out_data_r};

  always_comb begin
    y_cur = stg_r[STG_W] ? (pow_rdv_r ? pow_rd_r : '0)
                         : (base_rdv_r ? POW_W'(base_rd_r) : '0);
    w_cur = stg_r[STG_W] ? pw_r : bw_r;
    diff  = $signed({1'b0, x_r}) - $signed({1'b0, y_cur});
    prod_rnd = prod_r + $signed(acrms_pkg::PROD_W'(1) <<< (WB - 1));
    step  = prod_rnd >>> WB;
    ynew  = y_r + step[POW_W-1:0];
    yb    = ynew[BASE_W-1:0];
    sq_rnd = {1'b0, sq_r} + ((acrms_pkg::SQ_W + 1)'(1) << (FB - 1));
    rad_wide = {ynew, {(2 * acrms_pkg::ROOT_FRAC){1'b0}}};
    rem_sh = {rem_r[ROOT_W-1:0], v_r[RAD_W-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  always_comb begin
    state_nxt     = state_r;
    stg_nxt       = stg_r;
    xs_nxt        = xs_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    prod_nxt      = prod_r;
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_stg        = stg_r + 1'b1;
    wr_en         = 1'b0;

    unique case (state_r)
      acrms_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          xs_nxt    = {in_tdata[acrms_pkg::SAMPLE_BITS-1:0], {FB{1'b0}}};
          x_nxt     = POW_W'({in_tdata[acrms_pkg::SAMPLE_BITS-1:0], {FB{1'b0}}});
          stg_nxt   = '0;
          rd_en     = 1'b1;
          rd_stg    = '0;
          state_nxt = acrms_pkg::ST_MUL;
        end
      end
      acrms_pkg::ST_MUL: begin
        y_nxt     = y_cur;
        prod_nxt  = diff * $signed({1'b0, w_cur});
        rd_en     = (stg_r != {(STG_W + 1){1'b1}});
        state_nxt = acrms_pkg::ST_UPD;
      end
      acrms_pkg::ST_UPD: begin
        wr_en   = 1'b1;
        x_nxt   = ynew;
        stg_nxt = stg_r + 1'b1;
        if (stg_r == (STG_W + 1)'(acrms_pkg::STAGES - 1)) begin
          mag_nxt   = (xs_r >= yb) ? (xs_r - yb) : (yb - xs_r);
          state_nxt = acrms_pkg::ST_SQR;
        end else if (stg_r == {(STG_W + 1){1'b1}}) begin
          v_nxt     = rad_wide[FB +: RAD_W];
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          state_nxt = acrms_pkg::ST_ROOT;
        end else begin
          state_nxt = acrms_pkg::ST_MUL;
        end
      end
      acrms_pkg::ST_SQR: begin
        sq_nxt    = mag_r * mag_r;
        state_nxt = acrms_pkg::ST_PIN;
      end
      acrms_pkg::ST_PIN: begin
        x_nxt     = sq_rnd[FB +: POW_W];
        state_nxt = acrms_pkg::ST_MUL;
      end
      acrms_pkg::ST_ROOT: begin
        v_nxt = {v_r[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = acrms_pkg::ST_DONE;
        end
      end
      acrms_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acrms_pkg::OUT_W'(root_r);
          state_nxt     = acrms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acrms_pkg::ST_IDLE;
      end
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acrms_pkg::ST_IDLE;
      stg_r       <= '0;
      out_valid_r <= 1'b0;
      base_vld_r  <= '0;
      pow_vld_r   <= '0;
      bw_r        <= acrms_pkg::WEIGHT_RESET;
      pw_r        <= acrms_pkg::WEIGHT_RESET;
    end else begin
      state_r     <= state_nxt;
      stg_r       <= stg_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        if (stg_r[STG_W]) begin
          pow_vld_r[stg_r[STG_W-1:0]] <= 1'b1;
        end else begin
          base_vld_r[stg_r[STG_W-1:0]] <= 1'b1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          acrms_pkg::REG_BASELINE_WEIGHT: bw_r <= cfg_wdata[WB-1:0];
          acrms_pkg::REG_POWER_WEIGHT:    pw_r <= cfg_wdata[WB-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    xs_r       <= xs_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    mag_r      <= mag_nxt;
    sq_r       <= sq_nxt;
    v_r        <= v_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // stage memories, one read port and one write port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (stg_r[STG_W]) begin
        pow_mem[stg_r[STG_W-1:0]] <= ynew;
      end else begin
        base_mem[stg_r[STG_W-1:0]] <= yb;
      end
    end
    if (rd_en) begin
      if (rd_stg[STG_W]) begin
        pow_rd_r  <= pow_mem[rd_stg[STG_W-1:0]];
        pow_rdv_r <= pow_vld_r[rd_stg[STG_W-1:0]];
      end else begin
        base_rd_r  <= base_mem[rd_stg[STG_W-1:0]];
        base_rdv_r <= base_vld_r[rd_stg[STG_W-1:0]];
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for ac_rms_envelope_detector_unit
// predicts each rms level from accepted samples and checks results in order
// depends on acrms_pkg and the rtl of ac_rms_envelope_detector_unit
`timescale 1ns / 1ps

module tb_top;

  localparam int WEIGHT_BITS = acrms_pkg::WEIGHT_BITS;
  localparam int SAMPLE_W    = acrms_pkg::SAMPLE_W;
  localparam int IN_TDATA_W  = acrms_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = acrms_pkg::OUT_TDATA_W;
  localparam int CFG_ADDR_W  = acrms_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = acrms_pkg::CFG_DATA_W;
  localparam int BASE_W      = acrms_pkg::BASE_W;
  localparam int POW_W       = acrms_pkg::POW_W;
  localparam int STAGES      = acrms_pkg::STAGES;
  localparam int OUT_W       = acrms_pkg::OUT_W;
  localparam int FRAC_BITS   = acrms_pkg::FRAC_BITS;

  localparam int LIMIT       = 1_000_000;
  localparam int SETTLE      = 60;
  localparam int HOLD_CYCLES = 800;
  localparam int PHASE_ITEMS = 155;
  localparam int PHASES      = 8;

  localparam bit [WEIGHT_BITS-1:0] W_MAX = '1;
  localparam bit [SAMPLE_W-1:0]    S_MAX = '1;

  typedef enum {SRC_UNIFORM, SRC_RAILS, SRC_DC_NOISE} sample_src_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [11:0] sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [19:0] rms_level
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  bit hold_req = 1'b0;
  int cycles   = 0;

  // tracks weights and filter state, queues the predicted rms levels
  class rms_checker;
    bit [WEIGHT_BITS-1:0] base_w;
    bit [WEIGHT_BITS-1:0] pow_w;
    bit [BASE_W-1:0]      baseline [STAGES];
    bit [POW_W-1:0]       power [STAGES];
    bit [OUT_W-1:0]       pending_levels [$];
    int                   mismatches;

    function new();
      base_w     = acrms_pkg::WEIGHT_RESET;
      pow_w      = acrms_pkg::WEIGHT_RESET;
      mismatches = 0;
      foreach (baseline[i]) baseline[i] = '0;
      foreach (power[i]) power[i] = '0;
    endfunction

    function void set_weight(bit [CFG_ADDR_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      if (idx == acrms_pkg::REG_BASELINE_WEIGHT) base_w = val;
      else if (idx == acrms_pkg::REG_POWER_WEIGHT) pow_w = val;
    endfunction

    // one average stage, round half up
    function bit [63:0] smooth(bit [WEIGHT_BITS-1:0] w, bit [63:0] x, bit [63:0] y);
      bit [63:0] acc;
      acc = 64'(w) * x + ((64'd1 << WEIGHT_BITS) - 64'(w)) * y + (64'd1 << (WEIGHT_BITS - 1));
      return acc >> WEIGHT_BITS;
    endfunction

    function bit [OUT_W-1:0] floor_root(bit [63:0] v);
      bit [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b >>= 2;
      end
      return r[OUT_W-1:0];
    endfunction

    function void note_sample(bit [SAMPLE_W-1:0] s);
      bit [63:0] x, stage_in, mag, p;
      x = 64'(s) << FRAC_BITS;
      stage_in = x;
      for (int i = 0; i < STAGES; i++) begin
        baseline[i] = BASE_W'(smooth(base_w, stage_in, 64'(baseline[i])));
        stage_in = 64'(baseline[i]);
      end
      mag = (x >= 64'(baseline[STAGES-1])) ? x - 64'(baseline[STAGES-1])
                                            : 64'(baseline[STAGES-1]) - x;
      p = (mag * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      stage_in = p;
      for (int i = 0; i < STAGES; i++) begin
        power[i] = POW_W'(smooth(pow_w, stage_in, 64'(power[i])));
        stage_in = 64'(power[i]);
      end
      pending_levels.push_back(floor_root(64'(power[STAGES-1]) << (16 - FRAC_BITS)));
    endfunction

    function void check_level(bit [OUT_W-1:0] got);
      bit [OUT_W-1:0] want;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("rms_level %0d arrived with no sample pending", got);
        return;
      end
      want = pending_levels.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("rms_level mismatch: expected %0d (0x%05h), got %0d (0x%05h)",
                   want, want, got, got);
      end
    endfunction

    function int pending();
      return pending_levels.size();
    endfunction
  endclass

  rms_checker sb;

  ac_rms_envelope_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_level(out_tdata[OUT_W-1:0]);
  end

  // receiver: stall pattern changes per segment, long hold-off on request
  initial begin
    int seg_left, hold_left;
    rx_pattern_t pat;
    seg_left  = 0;
    hold_left = 0;
    pat       = RX_OPEN;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          pat      = rx_pattern_t'($urandom_range(0, 3));
          seg_left = int'($urandom_range(20, 200));
        end
        seg_left--;
        case (pat)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
          default:   out_tready <= ~out_tready;
        endcase
      end
    end
  end

  task automatic send_sample(input bit [SAMPLE_W-1:0] s);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(s);
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input bit [CFG_ADDR_W-1:0] idx, input bit [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_weight(idx, val);
    @(posedge clk);
  endtask

  // wait for every pending result, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int burst_left, gap, v;
    sample_src_t src;
    bit [SAMPLE_W-1:0] dc, s;
    burst_left = 0;
    src = SRC_UNIFORM;
    dc  = '0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = int'($urandom_range(1, 24));
        src = sample_src_t'($urandom_range(0, 2));
        dc  = SAMPLE_W'($urandom_range(0, int'(S_MAX)));
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 60));
        if (i > 0 && gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      case (src)
        SRC_UNIFORM: s = SAMPLE_W'($urandom_range(0, int'(S_MAX)));
        SRC_RAILS:   s = $urandom_range(0, 1) ? S_MAX : '0;
        default: begin
          v = int'(dc) + int'($urandom_range(0, 256)) - 128;
          s = (v < 0) ? '0 : (v > int'(S_MAX)) ? S_MAX : SAMPLE_W'(v);
        end
      endcase
      send_sample(s);
    end
  endtask

  initial begin
    bit [WEIGHT_BITS-1:0] bw, pw;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weights, rails and alternating bits
    send_sample('0);
    send_sample(S_MAX);
    send_sample('0);
    send_sample(S_MAX);
    send_sample(12'hAAA);
    send_sample(12'h555);
    settle();

    // largest weights, then zeros to pull the baseline down to zero
    write_reg(acrms_pkg::REG_BASELINE_WEIGHT, W_MAX);
    write_reg(acrms_pkg::REG_POWER_WEIGHT, W_MAX);
    send_sample(S_MAX);
    send_sample('0);
    send_sample(S_MAX);
    repeat (4) send_sample('0);
    settle();

    // zero baseline weight: baseline frozen, ac part is the whole sample
    write_reg(acrms_pkg::REG_BASELINE_WEIGHT, '0);
    send_sample(S_MAX);
    send_sample(12'd1);
    send_sample(12'h800);
    send_sample(12'h7FF);
    settle();

    // zero power weight: power frozen
    write_reg(acrms_pkg::REG_BASELINE_WEIGHT, W_MAX);
    write_reg(acrms_pkg::REG_POWER_WEIGHT, '0);
    send_sample(S_MAX);
    send_sample('0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin bw = acrms_pkg::WEIGHT_RESET; pw = acrms_pkg::WEIGHT_RESET; end
        1: begin bw = W_MAX; pw = W_MAX; end
        2: begin bw = 16'd1; pw = W_MAX; end
        3: begin
          bw = WEIGHT_BITS'($urandom_range(1, 4000));
          pw = WEIGHT_BITS'($urandom_range(1, 4000));
        end
        4: begin bw = '0; pw = '0; end
        5: begin bw = W_MAX; pw = WEIGHT_BITS'($urandom_range(1, 65534)); end
        default: begin bw = WEIGHT_BITS'($urandom); pw = WEIGHT_BITS'($urandom); end
      endcase
      write_reg(acrms_pkg::REG_BASELINE_WEIGHT, bw);
      write_reg(acrms_pkg::REG_POWER_WEIGHT, pw);
      // long receiver hold-off while samples keep coming
      if (p == 2 || p == 5) hold_req = 1'b1;
      run_random(PHASE_ITEMS);
      settle();
    end

    if (sb.pending() != 0) $display("%0d rms_level results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/acrms_pkg.sv
rtl/ac_rms_envelope_detector_unit.sv
dv/tb_top.sv
